// File: rtl/ubx_nav_solution_deframer_defines.svh
// Assertion macros shared by the checker of the UBX navigation deframer.
// No dependencies.
`ifndef UBX_NAV_SOLUTION_DEFRAMER_DEFINES_SVH
`define UBX_NAV_SOLUTION_DEFRAMER_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define UBX_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define UBX_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ubxnav_pkg.sv
// Types and constants of the UBX navigation-solution deframer.
// No dependencies; used by the parser, the top level and the checker.
`default_nettype none

package ubxnav_pkg;

   typedef enum logic [2:0] {
      PH_HUNT1   = 3'd0,
      PH_HUNT2   = 3'd1,
      PH_HEADER  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHECK   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_BAD_CHECK = 3'd1,
      ST_NO_FIX    = 3'd2,
      ST_OTHER_MSG = 3'd3,
      ST_TOO_LONG  = 3'd4,
      ST_TOO_SHORT = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CSR_SYNC_FIRST  = 3'd0,
      CSR_SYNC_SECOND = 3'd1,
      CSR_WANTED_MSG  = 3'd2,
      CSR_FIX_OK_MASK = 3'd3,
      CSR_MAX_FRAME   = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [7:0]  SYNC_FIRST_RST  = 8'd181;
   localparam logic [7:0]  SYNC_SECOND_RST = 8'd98;
   localparam logic [15:0] WANTED_MSG_RST  = 16'd262;
   localparam logic [7:0]  FIX_OK_MASK_RST = 8'd1;
   localparam logic [16:0] MAX_FRAME_RST   = 17'd64;

   localparam logic [15:0] HEADER_LAST  = 16'd3;
   localparam logic [15:0] MIN_SOL_LEN  = 16'd48;
   localparam int          OFF_FIX      = 10;
   localparam int          OFF_FLAGS    = 11;
   localparam int          OFF_POS      = 12;
   localparam int          OFF_VEL      = 28;
   localparam int          OFF_SATS     = 47;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [15:0] wanted_message;
      logic [7:0]  fix_ok_mask;
      logic [16:0] max_frame_bytes;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         fix_kind;
      logic [7:0]         satellites;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/ubxnav_parser.sv
// Frame state machine of the UBX deframer: sync hunt, header, payload
// captures and Fletcher-8 check. Depends on ubxnav_pkg.
`default_nettype none

module ubxnav_parser
   import ubxnav_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output logic            emit,
   output result_type      result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [15:0] msg_ff, msg_in, len_ff, len_in;
   logic [7:0]  chk_ff, chk_in;
   logic [7:0]  flags_ff, flags_in, fix_ff, fix_in, sat_ff, sat_in;
   logic [31:0] pos_ff [3];
   logic [31:0] pos_in [3];
   logic [31:0] vel_ff [3];
   logic [31:0] vel_in [3];

   logic [7:0]  sum_a_new, sum_b_new;
   logic [15:0] len_full, count_inc;
   logic        too_long, header_last, payload_last;
   status_type  status;

   assign sum_a_new    = sum_a_ff + rx_byte;
   assign sum_b_new    = sum_b_ff + sum_a_new;
   assign len_full     = {rx_byte, len_ff[7:0]};
   assign too_long     = ({1'b0, len_full} + 17'd2) > cfg.max_frame_bytes;
   assign header_last  = (count_ff == HEADER_LAST);
   assign count_inc    = count_ff + 16'd1;
   assign payload_last = (count_inc >= len_ff);

   // Next state
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            PH_HUNT1: begin
               if (rx_byte == cfg.sync_first) phase_in = PH_HUNT2;
            end
            PH_HUNT2: begin
               phase_in = (rx_byte == cfg.sync_second) ? PH_HEADER : PH_HUNT1;
            end
            PH_HEADER: begin
               if (header_last) begin
                  if (too_long)                phase_in = PH_HUNT1;
                  else if (len_full == 16'd0)  phase_in = PH_CHECK;
                  else                         phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (payload_last) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               if (count_ff != 16'd0) phase_in = PH_HUNT1;
            end
            default: phase_in = PH_HUNT1;
         endcase
      end
   end

   // Counter, check sums and captures
   always_comb begin
      count_in = count_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      msg_in   = msg_ff;
      len_in   = len_ff;
      chk_in   = chk_ff;
      flags_in = flags_ff;
      fix_in   = fix_ff;
      sat_in   = sat_ff;
      pos_in   = pos_ff;
      vel_in   = vel_ff;
      if (step) begin
         case (phase_ff)
            PH_HUNT1: ;
            PH_HUNT2: begin
               if (rx_byte == cfg.sync_second) begin
                  count_in = '0;
                  sum_a_in = '0;
                  sum_b_in = '0;
                  msg_in   = '0;
                  len_in   = '0;
                  chk_in   = '0;
                  flags_in = '0;
                  fix_in   = '0;
                  sat_in   = '0;
                  for (int w = 0; w < 3; w++) begin
                     pos_in[w] = '0;
                     vel_in[w] = '0;
                  end
               end
            end
            PH_HEADER: begin
               sum_a_in = sum_a_new;
               sum_b_in = sum_b_new;
               case (count_ff[1:0])
                  2'd0:    msg_in[15:8] = rx_byte;
                  2'd1:    msg_in[7:0]  = rx_byte;
                  2'd2:    len_in[7:0]  = rx_byte;
                  default: len_in[15:8] = rx_byte;
               endcase
               count_in = header_last ? 16'd0 : count_inc;
            end
            PH_PAYLOAD: begin
               sum_a_in = sum_a_new;
               sum_b_in = sum_b_new;
               if (count_ff == 16'(OFF_FIX))   fix_in   = rx_byte;
               if (count_ff == 16'(OFF_FLAGS)) flags_in = rx_byte;
               if (count_ff == 16'(OFF_SATS))  sat_in   = rx_byte;
               for (int w = 0; w < 3; w++) begin
                  for (int k = 0; k < 4; k++) begin
                     if (count_ff == 16'(OFF_POS + 4 * w + k)) pos_in[w][8 * k +: 8] = rx_byte;
                     if (count_ff == 16'(OFF_VEL + 4 * w + k)) vel_in[w][8 * k +: 8] = rx_byte;
                  end
               end
               count_in = payload_last ? 16'd0 : count_inc;
            end
            PH_CHECK: begin
               if (count_ff == 16'd0) begin
                  chk_in   = rx_byte;
                  count_in = 16'd1;
               end else begin
                  count_in = '0;
               end
            end
            default: count_in = '0;
         endcase
      end
   end

   // Result
   always_comb begin
      emit   = 1'b0;
      status = ST_TOO_LONG;
      if (step && phase_ff == PH_HEADER && header_last && too_long) begin
         emit = 1'b1;
      end else if (step && phase_ff == PH_CHECK && count_ff != 16'd0) begin
         emit = 1'b1;
         if (chk_ff != sum_a_ff || rx_byte != sum_b_ff) status = ST_BAD_CHECK;
         else if (msg_ff != cfg.wanted_message)        status = ST_OTHER_MSG;
         else if (len_ff < MIN_SOL_LEN)                status = ST_TOO_SHORT;
         else if ((flags_ff & cfg.fix_ok_mask) == '0)  status = ST_NO_FIX;
         else                                          status = ST_ACCEPTED;
      end
      result = '0;
      result.status = status;
      if (status == ST_ACCEPTED) begin
         result.fix_kind   = fix_ff;
         result.satellites = sat_ff;
         result.pos_x      = $signed(pos_ff[0]);
         result.pos_y      = $signed(pos_ff[1]);
         result.pos_z      = $signed(pos_ff[2]);
         result.vel_x      = $signed(vel_ff[0]);
         result.vel_y      = $signed(vel_ff[1]);
         result.vel_z      = $signed(vel_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Cleared at every frame start, so no reset needed
   always_ff @(posedge clock) begin
      sum_a_ff <= sum_a_in;
      sum_b_ff <= sum_b_in;
      msg_ff   <= msg_in;
      len_ff   <= len_in;
      chk_ff   <= chk_in;
      flags_ff <= flags_in;
      fix_ff   <= fix_in;
      sat_ff   <= sat_in;
      pos_ff   <= pos_in;
      vel_ff   <= vel_in;
   end

endmodule

`default_nettype wire

// File: rtl/ubx_nav_solution_deframer.sv
// Path: the byte that ends a frame passes the input register, then the parser
// into the result register, which loads with the frame's result.
// Throughput: one byte per cycle; a stalled result holds the parser, so the
// input register keeps one byte and then drops req_ready until rsp_ready.
// Reset (synchronous, active high): config to defaults, valids clear, parser hunts sync.
// Top level of the UBX deframer. Depends on ubxnav_pkg and ubxnav_parser.
`default_nettype none

module ubx_nav_solution_deframer
   import ubxnav_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_rx_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic [7:0]                  rsp_fix_kind,
   output logic [7:0]                  rsp_satellites,
   output logic signed [31:0]          rsp_pos_x,
   output logic signed [31:0]          rsp_pos_y,
   output logic signed [31:0]          rsp_pos_z,
   output logic signed [31:0]          rsp_vel_x,
   output logic signed [31:0]          rsp_vel_y,
   output logic signed [31:0]          rsp_vel_z,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       advance, emit;
   result_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_FIRST:  cfg_in.sync_first      = csr_data[7:0];
            CSR_SYNC_SECOND: cfg_in.sync_second     = csr_data[7:0];
            CSR_WANTED_MSG:  cfg_in.wanted_message  = csr_data[15:0];
            CSR_FIX_OK_MASK: cfg_in.fix_ok_mask     = csr_data[7:0];
            CSR_MAX_FRAME:   cfg_in.max_frame_bytes = csr_data[16:0];
            default: ;
         endcase
      end
   end

   // Advance the held byte only when the result register has room
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (advance)           in_valid_in = 1'b0;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit)           out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   ubxnav_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .emit    (emit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first      <= SYNC_FIRST_RST;
         cfg_ff.sync_second     <= SYNC_SECOND_RST;
         cfg_ff.wanted_message  <= WANTED_MSG_RST;
         cfg_ff.fix_ok_mask     <= FIX_OK_MASK_RST;
         cfg_ff.max_frame_bytes <= MAX_FRAME_RST;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
      if (emit)                   out_ff     <= result;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_fix_kind   = out_ff.fix_kind;
   assign rsp_satellites = out_ff.satellites;
   assign rsp_pos_x      = out_ff.pos_x;
   assign rsp_pos_y      = out_ff.pos_y;
   assign rsp_pos_z      = out_ff.pos_z;
   assign rsp_vel_x      = out_ff.vel_x;
   assign rsp_vel_y      = out_ff.vel_y;
   assign rsp_vel_z      = out_ff.vel_z;

endmodule

`default_nettype wire

// File: rtl/ubxnav_checker.sv
// Port-level assertions for the UBX deframer, bound to the top level.
// Depends on ubxnav_pkg and ubx_nav_solution_deframer_defines.svh.
`default_nettype none
`include "ubx_nav_solution_deframer_defines.svh"

module ubxnav_checker
   import ubxnav_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic [2:0]             rsp_status,
   input  wire logic [7:0]             rsp_fix_kind,
   input  wire logic [7:0]             rsp_satellites,
   input  wire logic signed [31:0]     rsp_pos_x,
   input  wire logic signed [31:0]     rsp_pos_y,
   input  wire logic signed [31:0]     rsp_pos_z,
   input  wire logic signed [31:0]     rsp_vel_x,
   input  wire logic signed [31:0]     rsp_vel_y,
   input  wire logic signed [31:0]     rsp_vel_z
);

   logic         fields_zero;
   logic [210:0] rsp_payload;

   assign fields_zero = rsp_fix_kind == '0 && rsp_satellites == '0 &&
                        rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_pos_z == '0 &&
                        rsp_vel_x == '0 && rsp_vel_y == '0 && rsp_vel_z == '0;

   assign rsp_payload = {rsp_status, rsp_fix_kind, rsp_satellites, rsp_pos_x, rsp_pos_y,
                         rsp_pos_z, rsp_vel_x, rsp_vel_y, rsp_vel_z};

   `UBX_ASSERT(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "result valid after reset")
   `UBX_ASSERT_RST(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload),
      "stalled result changed")
   `UBX_ASSERT_RST(a_req_hold, clock, reset,
      req_valid && !req_ready |=> req_valid && $stable(req_rx_byte),
      "waiting request changed")
   `UBX_ASSERT_RST(a_status_legal, clock, reset,
      rsp_valid |-> rsp_status <= ST_TOO_SHORT, "status code out of range")
   `UBX_ASSERT_RST(a_reject_zero, clock, reset,
      rsp_valid && rsp_status != ST_ACCEPTED |-> fields_zero,
      "rejected frame carries fields")

endmodule

bind ubx_nav_solution_deframer ubxnav_checker u_checker (.*);

`default_nettype wire

// File: test/tb_ubx_nav_solution_deframer.sv
// Self-checking testbench of the UBX navigation-solution deframer: framed byte
// streams in, one checked status/solution beat out per complete frame or long header.
// Depends on ubxnav_pkg and the ubx_nav_solution_deframer RTL.
`default_nettype none

module tb_ubx_nav_solution_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import ubxnav_pkg::*;

   localparam int CYCLE_LIMIT = 600_000;

   typedef enum {FIX_ANY, FIX_SET, FIX_CLEAR} fix_mode_type;
   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EXTREME} fill_type;

   // Mirrors the deframer state byte by byte and holds the solutions owed.
   class nav_solution_scoreboard;
      cfg_type     cfg;
      phase_type   phase;
      logic [15:0] byte_count;
      logic [15:0] message_id;
      logic [15:0] payload_length;
      logic [7:0]  sum_a;
      logic [7:0]  sum_b;
      logic [7:0]  first_check;
      logic [7:0]  fix_flags;
      logic [7:0]  fix_capture;
      logic [7:0]  sat_capture;
      logic [31:0] pos_capture [3];
      logic [31:0] vel_capture [3];
      result_type  expected_solutions [$];
      int          solutions_predicted;
      int          errors;

      function new();
         cfg = '{SYNC_FIRST_RST, SYNC_SECOND_RST, WANTED_MSG_RST, FIX_OK_MASK_RST,
                 MAX_FRAME_RST};
         phase = PH_HUNT1;
         clear_frame();
         solutions_predicted = 0;
         errors = 0;
      endfunction

      function void clear_frame();
         byte_count = '0;
         message_id = '0;
         payload_length = '0;
         sum_a = '0;
         sum_b = '0;
         first_check = '0;
         fix_flags = '0;
         fix_capture = '0;
         sat_capture = '0;
         for (int i = 0; i < 3; i++) begin
            pos_capture[i] = '0;
            vel_capture[i] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_SYNC_FIRST:  cfg.sync_first = value[7:0];
            CSR_SYNC_SECOND: cfg.sync_second = value[7:0];
            CSR_WANTED_MSG:  cfg.wanted_message = value[15:0];
            CSR_FIX_OK_MASK: cfg.fix_ok_mask = value[7:0];
            CSR_MAX_FRAME:   cfg.max_frame_bytes = value;
            default: ;
         endcase
      endfunction

      function result_type status_only(status_type st);
         result_type r;
         r = '0;
         r.status = st;
         return r;
      endfunction

      function void add_sum(logic [7:0] b);
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
      endfunction

      function void note_rx_byte(logic [7:0] b);
         result_type  r;
         bit          issue;
         int          off;
         logic [16:0] frame_total;
         issue = 1'b0;
         case (phase)
            PH_HUNT1: begin
               if (b == cfg.sync_first) phase = PH_HUNT2;
            end
            PH_HUNT2: begin
               // a mismatch is consumed, even when it equals the first sync byte
               if (b == cfg.sync_second) begin
                  phase = PH_HEADER;
                  clear_frame();
               end else begin
                  phase = PH_HUNT1;
               end
            end
            PH_HEADER: begin
               add_sum(b);
               case (byte_count)
                  16'd0:   message_id[15:8] = b;
                  16'd1:   message_id[7:0] = b;
                  16'd2:   payload_length[7:0] = b;
                  default: payload_length[15:8] = b;
               endcase
               if (byte_count < HEADER_LAST) begin
                  byte_count++;
               end else begin
                  byte_count = '0;
                  frame_total = {1'b0, payload_length} + 17'd2;
                  if (frame_total > cfg.max_frame_bytes) begin
                     phase = PH_HUNT1;
                     r = status_only(ST_TOO_LONG);
                     issue = 1'b1;
                  end else begin
                     phase = (payload_length == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               add_sum(b);
               off = byte_count;
               if (off == OFF_FIX) fix_capture = b;
               else if (off == OFF_FLAGS) fix_flags = b;
               else if (off == OFF_SATS) sat_capture = b;
               else if (off >= OFF_POS && off < OFF_POS + 12)
                  pos_capture[(off - OFF_POS) / 4][8 * ((off - OFF_POS) % 4) +: 8] = b;
               else if (off >= OFF_VEL && off < OFF_VEL + 12)
                  vel_capture[(off - OFF_VEL) / 4][8 * ((off - OFF_VEL) % 4) +: 8] = b;
               byte_count++;
               if (byte_count >= payload_length) begin
                  byte_count = '0;
                  phase = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (byte_count == 16'd0) begin
                  first_check = b;
                  byte_count = 16'd1;
               end else begin
                  byte_count = '0;
                  phase = PH_HUNT1;
                  issue = 1'b1;
                  if (first_check != sum_a || b != sum_b) r = status_only(ST_BAD_CHECK);
                  else if (message_id != cfg.wanted_message) r = status_only(ST_OTHER_MSG);
                  else if (payload_length < MIN_SOL_LEN) r = status_only(ST_TOO_SHORT);
                  else if ((fix_flags & cfg.fix_ok_mask) == 8'd0) r = status_only(ST_NO_FIX);
                  else begin
                     r = status_only(ST_ACCEPTED);
                     r.fix_kind = fix_capture;
                     r.satellites = sat_capture;
                     r.pos_x = pos_capture[0];
                     r.pos_y = pos_capture[1];
                     r.pos_z = pos_capture[2];
                     r.vel_x = vel_capture[0];
                     r.vel_y = vel_capture[1];
                     r.vel_z = vel_capture[2];
                  end
               end
            end
            default: begin
               phase = PH_HUNT1;
               byte_count = '0;
            end
         endcase
         if (issue) begin
            expected_solutions.push_back(r);
            solutions_predicted++;
         end
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_solution(result_type got);
         result_type want;
         if (expected_solutions.size() == 0) begin
            report_mismatch($sformatf("result beat with none expected, status %0d", got.status));
            return;
         end
         want = expected_solutions.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.fix_kind !== want.fix_kind)
            report_mismatch($sformatf("fix_kind %h, expected %h", got.fix_kind, want.fix_kind));
         if (got.satellites !== want.satellites)
            report_mismatch($sformatf("satellites %h, expected %h", got.satellites,
                                      want.satellites));
         if (got.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x %h, expected %h", got.pos_x, want.pos_x));
         if (got.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y %h, expected %h", got.pos_y, want.pos_y));
         if (got.pos_z !== want.pos_z)
            report_mismatch($sformatf("pos_z %h, expected %h", got.pos_z, want.pos_z));
         if (got.vel_x !== want.vel_x)
            report_mismatch($sformatf("vel_x %h, expected %h", got.vel_x, want.vel_x));
         if (got.vel_y !== want.vel_y)
            report_mismatch($sformatf("vel_y %h, expected %h", got.vel_y, want.vel_y));
         if (got.vel_z !== want.vel_z)
            report_mismatch($sformatf("vel_z %h, expected %h", got.vel_z, want.vel_z));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_status;
   logic [7:0]             rsp_fix_kind;
   logic [7:0]             rsp_satellites;
   logic signed [31:0]     rsp_pos_x;
   logic signed [31:0]     rsp_pos_y;
   logic signed [31:0]     rsp_pos_z;
   logic signed [31:0]     rsp_vel_x;
   logic signed [31:0]     rsp_vel_y;
   logic signed [31:0]     rsp_vel_z;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   nav_solution_scoreboard sb;
   bit                     idle_on = 1'b1;
   int                     bytes_sent = 0;
   int                     cycle_count = 0;

   ubx_nav_solution_deframer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_fix_kind     (rsp_fix_kind),
      .rsp_satellites   (rsp_satellites),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_vel_x        (rsp_vel_x),
      .rsp_vel_y        (rsp_vel_y),
      .rsp_vel_z        (rsp_vel_z),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_solution('{status: status_type'(rsp_status), fix_kind: rsp_fix_kind,
                             satellites: rsp_satellites, pos_x: rsp_pos_x,
                             pos_y: rsp_pos_y, pos_z: rsp_pos_z, vel_x: rsp_vel_x,
                             vel_y: rsp_vel_y, vel_z: rsp_vel_z});
   end

   // Result side back-pressure in bursts.
   initial begin : rsp_stall
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 10);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_rx_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [15:0] msg, input int len,
                             input fix_mode_type fix_mode, input fill_type fill,
                             input bit corrupt, input int cut);
      logic [7:0]  frame_q [$];
      logic [7:0]  body;
      logic [15:0] len16;
      logic [7:0]  ck_a;
      logic [7:0]  ck_b;
      int          k;
      int          word;
      int          lane;
      len16 = len[15:0];
      frame_q.push_back(sb.cfg.sync_first);
      frame_q.push_back(sb.cfg.sync_second);
      frame_q.push_back(msg[15:8]);
      frame_q.push_back(msg[7:0]);
      frame_q.push_back(len16[7:0]);
      frame_q.push_back(len16[15:8]);
      for (k = 0; k < len; k++) begin
         word = (k - OFF_POS) / 4;
         lane = (k - OFF_POS) % 4;
         case (fill)
            FILL_ZERO: body = 8'h00;
            FILL_ONES: body = 8'hFF;
            FILL_EXTREME: begin
               // alternate most negative and most positive words
               if (k >= OFF_POS && k < OFF_VEL + 12)
                  body = word[0] ? ((lane == 3) ? 8'h7F : 8'hFF) : ((lane == 3) ? 8'h80 : 8'h00);
               else
                  body = 8'($urandom);
            end
            default: body = 8'($urandom);
         endcase
         if (k == OFF_FLAGS && fix_mode == FIX_SET) body |= sb.cfg.fix_ok_mask;
         if (k == OFF_FLAGS && fix_mode == FIX_CLEAR) body &= ~sb.cfg.fix_ok_mask;
         frame_q.push_back(body);
      end
      ck_a = 8'h00;
      ck_b = 8'h00;
      for (k = 2; k < frame_q.size(); k++) begin
         ck_a += frame_q[k];
         ck_b += ck_a;
      end
      if (corrupt) begin
         if ($urandom_range(0, 1) == 0) ck_a ^= 8'(1 << $urandom_range(0, 7));
         else ck_b ^= 8'(1 << $urandom_range(0, 7));
      end
      frame_q.push_back(ck_a);
      frame_q.push_back(ck_b);
      for (k = 0; k < frame_q.size() && (cut < 0 || k < cut); k++) send_byte(frame_q[k]);
   endtask

   // Clamp a payload length to the current frame limit, unless that limit lets none through.
   function automatic int frame_len(input int lo, input int hi);
      int limit;
      limit = int'(sb.cfg.max_frame_bytes) - 2;
      if (hi > limit) hi = limit;
      if (hi < lo) return (hi < 0) ? lo : $urandom_range(0, hi);
      return $urandom_range(lo, hi);
   endfunction

   task automatic random_frame();
      logic [15:0] msg;
      int          limit;
      int          len;
      msg = sb.cfg.wanted_message;
      limit = int'(sb.cfg.max_frame_bytes) - 2;
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4, 5, 6:
            send_frame(msg, frame_len(48, 72), FIX_SET,
                       ($urandom_range(0, 9) == 0) ? FILL_EXTREME : FILL_RANDOM, 1'b0, -1);
         7: send_frame(msg ^ 16'($urandom_range(1, 65535)), frame_len(0, 72), FIX_ANY,
                       FILL_RANDOM, 1'b0, -1);
         8: send_frame(msg, frame_len(0, 72), FIX_ANY, FILL_RANDOM, 1'b1, -1);
         9: send_frame(msg, frame_len(0, 47), FIX_SET, FILL_RANDOM, 1'b0, -1);
         10: send_frame(msg, frame_len(48, 72), FIX_CLEAR, FILL_RANDOM, 1'b0, -1);
         11: begin
            // header over the limit, then a few stray bytes
            if (limit < 65535) begin
               if (limit < 0) len = $urandom_range(0, 40);
               else len = $urandom_range(limit + 1, (limit + 40 > 65535) ? 65535 : limit + 40);
               send_frame(msg, len, FIX_ANY, FILL_RANDOM, 1'b0, 6 + $urandom_range(0, 3));
            end
         end
         12: send_frame(msg, frame_len(0, 72), FIX_SET, FILL_RANDOM, 1'b0,
                        $urandom_range(2, 20));
         13: begin
            send_byte(sb.cfg.sync_first);
            send_byte(8'($urandom));
         end
         default: send_frame(msg, frame_len(0, 72), FIX_ANY, FILL_RANDOM, 1'b0, -1);
      endcase
   endtask

   task automatic run_random(input int n_bytes, input int n_results);
      int bytes_at_start;
      int results_at_start;
      bytes_at_start = bytes_sent;
      results_at_start = sb.solutions_predicted;
      while (bytes_sent - bytes_at_start < n_bytes ||
             sb.solutions_predicted - results_at_start < n_results)
         random_frame();
   endtask

   // Drop valid, drain all owed results and let the pipeline empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_solutions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic apply_config(input cfg_type c);
      // junk in the unused upper bits must be ignored
      write_csr(CSR_SYNC_FIRST, {9'($urandom), c.sync_first});
      write_csr(CSR_SYNC_SECOND, {9'($urandom), c.sync_second});
      write_csr(CSR_WANTED_MSG, {1'($urandom), c.wanted_message});
      write_csr(CSR_FIX_OK_MASK, {9'($urandom), c.fix_ok_mask});
      write_csr(CSR_MAX_FRAME, c.max_frame_bytes);
      write_csr(3'($urandom_range(5, 7)), 17'($urandom));
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      cfg_type c;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames at the reset settings
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_FIRST_RST);
      send_byte(SYNC_FIRST_RST);
      send_frame(WANTED_MSG_RST, 48, FIX_SET, FILL_EXTREME, 1'b0, -1);
      send_frame(WANTED_MSG_RST, 62, FIX_SET, FILL_ONES, 1'b0, -1);
      send_frame(WANTED_MSG_RST, 48, FIX_SET, FILL_ZERO, 1'b0, -1);
      send_frame(WANTED_MSG_RST, 48, FIX_SET, FILL_RANDOM, 1'b1, -1);
      send_frame(WANTED_MSG_RST ^ 16'h0001, 48, FIX_SET, FILL_RANDOM, 1'b0, -1);
      send_frame(WANTED_MSG_RST, 0, FIX_ANY, FILL_RANDOM, 1'b0, -1);
      send_frame(WANTED_MSG_RST, 47, FIX_SET, FILL_RANDOM, 1'b0, -1);
      send_frame(WANTED_MSG_RST, 48, FIX_CLEAR, FILL_ONES, 1'b0, -1);
      send_frame(WANTED_MSG_RST, 63, FIX_ANY, FILL_RANDOM, 1'b0, 6);
      settle();

      c = '{8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom_range(1, 255)),
            17'($urandom_range(50, 120))};
      apply_config(c);
      run_random(150, 12);
      settle();

      c = '{8'h00, 8'hFF, 16'hFFFF, 8'hFF, 17'd65537};
      apply_config(c);
      run_random(100, 10);
      settle();

      // only empty payloads get past the header
      c = '{8'hFF, 8'h00, 16'h0000, 8'h80, 17'd2};
      apply_config(c);
      run_random(60, 8);
      settle();

      // equal sync bytes, every header too long
      c = '{8'h5A, 8'h5A, 16'($urandom), 8'h01, 17'd0};
      apply_config(c);
      run_random(40, 8);
      settle();

      c = '{8'($urandom), 8'($urandom), 16'($urandom), 8'h00, 17'h1FFFF};
      apply_config(c);
      run_random(100, 8);
      settle();

      // last stretch without idling, at a frame limit that lets every length through
      idle_on = 1'b0;
      c = '{SYNC_FIRST_RST, SYNC_SECOND_RST, WANTED_MSG_RST, FIX_OK_MASK_RST, 17'd65537};
      apply_config(c);
      run_random(80, 8);
      settle();

      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
